@@ sv/cll_pkg.sv @@
package cll_pkg;

    localparam int MODE_W = 3;
    localparam int CNT_W = 4;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_NEW     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MASTER  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONFIRM = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OLD     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ENTER   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OPEN    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS   = 2'd2;

    localparam logic [7:0] CHANGE_KEY = 8'h43;

    localparam logic [CNT_W-1:0]  RST_MAX_ATTEMPTS = 4'd3;
    localparam logic [TICK_W-1:0] RST_OPEN_TICKS   = 16'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              door_open;
        logic [CNT_W-1:0]  wrong_count;
        logic              locked_out;
    } t_result;

endpackage

@@ sv/code_lock_controller.sv @@
// Path: an accepted beat is registered at the input, its result is computed in one pass
// and registered in the result register; a result stall can hold the beat at the input.
// Throughput: one beat per cycle while the result side is not stalled; the lock state updates
// as the beat moves to the result register, so the next beat sees it without a bubble.
// Reset (synchronous, active low): new code mode, stored code and counts zero,
// master code 0, three attempts allowed, door held open for three ticks.
module code_lock_controller #(
    parameter int CODE_WIDTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [CODE_WIDTH-1:0]               i_code,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cll_pkg::MODE_W-1:0]          o_mode,
    output logic                                o_door_open,
    output logic [cll_pkg::CNT_W-1:0]           o_wrong_count,
    output logic                                o_locked_out,
    input  logic                                i_cfg_we,
    input  logic [cll_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [((CODE_WIDTH > cll_pkg::TICK_W) ? CODE_WIDTH : cll_pkg::TICK_W)-1:0]
                                                i_cfg_data
);

    logic [CODE_WIDTH-1:0]      r_master_code;
    logic [cll_pkg::CNT_W-1:0]  r_max_attempts;
    logic [cll_pkg::TICK_W-1:0] r_open_ticks;

    logic                       r_in_vld;
    logic                       r_func;
    logic [CODE_WIDTH-1:0]      r_code;
    logic                       r_out_vld;
    cll_pkg::t_result           r_result;
    cll_pkg::t_result           step_result;
    logic                       out_free;
    logic                       step;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_code  <= '0;
            r_max_attempts <= cll_pkg::RST_MAX_ATTEMPTS;
            r_open_ticks   <= cll_pkg::RST_OPEN_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cll_pkg::CFG_MASTER_CODE:  r_master_code  <= i_cfg_data[CODE_WIDTH-1:0];
                cll_pkg::CFG_MAX_ATTEMPTS: r_max_attempts <= i_cfg_data[cll_pkg::CNT_W-1:0];
                cll_pkg::CFG_OPEN_TICKS:   r_open_ticks   <= i_cfg_data[cll_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_func <= i_func;
            r_code <= i_code;
        end
    end

    cll_fsm #(
        .CODE_WIDTH(CODE_WIDTH)
    ) u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_func         (r_func),
        .i_code         (r_code),
        .i_master_code  (r_master_code),
        .i_max_attempts (r_max_attempts),
        .i_open_ticks   (r_open_ticks),
        .o_result       (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_mode        = r_result.mode;
    assign o_door_open   = r_result.door_open;
    assign o_wrong_count = r_result.wrong_count;
    assign o_locked_out  = r_result.locked_out;

    // A beat held at the input must stay there until the result register frees up.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_vld)
        else $error("input beat lost while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_result)))
        else $error("result beat changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_vld)
        else $error("computed result did not reach the output");

endmodule

@@ sv/cll_fsm.sv @@
module cll_fsm #(
    parameter int CODE_WIDTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_func,
    input  logic [CODE_WIDTH-1:0]       i_code,
    input  logic [CODE_WIDTH-1:0]       i_master_code,
    input  logic [cll_pkg::CNT_W-1:0]   i_max_attempts,
    input  logic [cll_pkg::TICK_W-1:0]  i_open_ticks,
    output cll_pkg::t_result            o_result
);

    localparam int KEY_W = (CODE_WIDTH > 8) ? CODE_WIDTH : 8;

    logic [cll_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [CODE_WIDTH-1:0]      r_stored, n_stored;
    logic [cll_pkg::CNT_W-1:0]  r_attempt, n_attempt;
    logic [cll_pkg::TICK_W-1:0] r_timer, n_timer;
    logic                       lockout;
    logic                       code_match;
    logic                       change_hit;
    logic [cll_pkg::CNT_W-1:0]  wrong_next;

    assign code_match = (i_code == r_stored);
    assign change_hit = (KEY_W'(i_code) == KEY_W'(cll_pkg::CHANGE_KEY));
    assign wrong_next = r_attempt + 1'b1;

    always_comb begin
        n_mode    = r_mode;
        n_stored  = r_stored;
        n_attempt = r_attempt;
        n_timer   = r_timer;
        lockout   = 1'b0;
        if (i_func) begin
            if (r_mode == cll_pkg::MODE_OPEN) begin
                if (r_timer <= cll_pkg::TICK_W'(1)) begin
                    n_timer   = '0;
                    n_mode    = cll_pkg::MODE_ENTER;
                    n_attempt = '0;
                end else begin
                    n_timer = r_timer - 1'b1;
                end
            end
        end else begin
            unique case (r_mode)
                cll_pkg::MODE_NEW: begin
                    n_stored  = i_code;
                    n_mode    = cll_pkg::MODE_CONFIRM;
                    n_attempt = '0;
                end
                cll_pkg::MODE_MASTER: begin
                    if (i_code == i_master_code) begin
                        n_mode    = cll_pkg::MODE_NEW;
                        n_attempt = '0;
                    end
                end
                cll_pkg::MODE_CONFIRM: begin
                    n_attempt = '0;
                    if (code_match) begin
                        n_mode  = cll_pkg::MODE_OPEN;
                        n_timer = i_open_ticks;
                    end else begin
                        n_mode = cll_pkg::MODE_NEW;
                    end
                end
                cll_pkg::MODE_OLD, cll_pkg::MODE_ENTER: begin
                    if (r_mode == cll_pkg::MODE_ENTER && change_hit) begin
                        n_mode    = cll_pkg::MODE_OLD;
                        n_attempt = '0;
                    end else if (code_match) begin
                        n_attempt = '0;
                        if (r_mode == cll_pkg::MODE_ENTER) begin
                            n_mode  = cll_pkg::MODE_OPEN;
                            n_timer = i_open_ticks;
                        end else begin
                            n_mode = cll_pkg::MODE_NEW;
                        end
                    end else if (wrong_next >= i_max_attempts) begin
                        n_mode    = cll_pkg::MODE_MASTER;
                        n_attempt = '0;
                        lockout   = 1'b1;
                    end else begin
                        n_attempt = wrong_next;
                    end
                end
                cll_pkg::MODE_OPEN: begin
                end
                default: begin
                    n_mode    = cll_pkg::MODE_NEW;
                    n_attempt = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= cll_pkg::MODE_NEW;
            r_stored  <= '0;
            r_attempt <= '0;
            r_timer   <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_stored  <= n_stored;
            r_attempt <= n_attempt;
            r_timer   <= n_timer;
        end
    end

    always_comb begin
        o_result.mode        = n_mode;
        o_result.door_open   = (n_mode == cll_pkg::MODE_OPEN);
        o_result.wrong_count = n_attempt;
        o_result.locked_out  = lockout;
    end

    // Wrong entries are only ever counted while a code is being checked.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_attempt != '0) |-> (r_mode == cll_pkg::MODE_ENTER || r_mode == cll_pkg::MODE_OLD))
        else $error("attempt count held outside enter or old mode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && lockout) |=> (r_mode == cll_pkg::MODE_MASTER && r_attempt == '0))
        else $error("lockout did not land in master mode with a clear count");

    // The open timer only runs down while the door is held open.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != cll_pkg::MODE_OPEN && $past(r_mode) != cll_pkg::MODE_OPEN) |-> $stable(r_timer))
        else $error("open timer moved while the door was closed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_func && r_mode != cll_pkg::MODE_OPEN) |=> $stable(r_mode))
        else $error("tick changed the mode with the door closed");

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 152;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 100;
    localparam int HOLD_AT      = 400;

    typedef struct {
        bit                              is_cfg;
        logic [cll_pkg::CFG_IDX_W-1:0]   idx;
        logic [15:0]                     data;
        logic                            func;
        logic [7:0]                      code;
        bit                              typed;
        cll_pkg::t_result                res;
    } t_dir_row;

    typedef struct {
        cll_pkg::t_result pred;
        bit               typed;
        cll_pkg::t_result typed_val;
    } t_pending;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_func = 1'b0;
    logic [7:0]                    i_code = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [cll_pkg::MODE_W-1:0]    o_mode;
    logic                          o_door_open;
    logic [cll_pkg::CNT_W-1:0]     o_wrong_count;
    logic                          o_locked_out;
    logic                          i_cfg_we = 1'b0;
    logic [cll_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0]                   i_cfg_data = '0;

    // Lock state as it should be after every accepted beat.
    logic [cll_pkg::MODE_W-1:0]    lk_mode;
    logic [7:0]                    lk_code;
    logic [cll_pkg::CNT_W-1:0]     lk_tries;
    logic [cll_pkg::TICK_W-1:0]    lk_timer;
    logic [7:0]                    reg_master;
    logic [cll_pkg::CNT_W-1:0]     reg_max_tries;
    logic [cll_pkg::TICK_W-1:0]    reg_open_ticks;

    t_pending          pending_results[$];
    t_dir_row          dir_table[$];
    bit                cur_typed = 1'b0;
    cll_pkg::t_result  cur_res = '0;
    bit                idle_en = 1'b1;
    int                hit_pct = 60;
    int                err_count = 0;
    int                results_seen = 0;
    int                quiet_cycles = 0;

    code_lock_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_code        (i_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mode        (o_mode),
        .o_door_open   (o_door_open),
        .o_wrong_count (o_wrong_count),
        .o_locked_out  (o_locked_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic cll_pkg::t_result mk_res(logic [cll_pkg::MODE_W-1:0] m, logic d,
                                                logic [cll_pkg::CNT_W-1:0] n, logic lo);
        cll_pkg::t_result r;
        r.mode = m;
        r.door_open = d;
        r.wrong_count = n;
        r.locked_out = lo;
        return r;
    endfunction

    function automatic void open_door();
        lk_mode = cll_pkg::MODE_OPEN;
        lk_tries = '0;
        lk_timer = reg_open_ticks;
    endfunction

    function automatic void back_to_new();
        lk_mode = cll_pkg::MODE_NEW;
        lk_tries = '0;
    endfunction

    // A wrong code in enter or old mode; returns 1 when it trips the lockout.
    function automatic bit note_miss();
        logic [cll_pkg::CNT_W-1:0] n;
        n = lk_tries + 1'b1;
        if (n >= reg_max_tries) begin
            lk_mode = cll_pkg::MODE_MASTER;
            lk_tries = '0;
            return 1'b1;
        end
        lk_tries = n;
        return 1'b0;
    endfunction

    function automatic cll_pkg::t_result predict_lock(logic tick, logic [7:0] c);
        logic lo;
        lo = 1'b0;
        if (tick) begin
            if (lk_mode == cll_pkg::MODE_OPEN) begin
                if (lk_timer <= 1) begin
                    lk_timer = '0;
                    lk_mode = cll_pkg::MODE_ENTER;
                    lk_tries = '0;
                end else begin
                    lk_timer = lk_timer - 1'b1;
                end
            end
        end else begin
            case (lk_mode)
                cll_pkg::MODE_NEW: begin
                    lk_code = c;
                    lk_mode = cll_pkg::MODE_CONFIRM;
                    lk_tries = '0;
                end
                cll_pkg::MODE_MASTER: begin
                    if (c == reg_master) back_to_new();
                end
                cll_pkg::MODE_CONFIRM: begin
                    if (c == lk_code) open_door();
                    else back_to_new();
                end
                cll_pkg::MODE_OLD: begin
                    if (c == lk_code) back_to_new();
                    else lo = note_miss();
                end
                cll_pkg::MODE_ENTER: begin
                    if (c == cll_pkg::CHANGE_KEY) begin
                        lk_mode = cll_pkg::MODE_OLD;
                        lk_tries = '0;
                    end else if (c == lk_code) begin
                        open_door();
                    end else begin
                        lo = note_miss();
                    end
                end
                cll_pkg::MODE_OPEN: ;
                default: back_to_new();
            endcase
        end
        return mk_res(lk_mode, lk_mode == cll_pkg::MODE_OPEN, lk_tries, lo);
    endfunction

    function automatic void compare_result(cll_pkg::t_result want, string src);
        if (want.mode !== o_mode || want.door_open !== o_door_open ||
            want.wrong_count !== o_wrong_count || want.locked_out !== o_locked_out) begin
            err_count++;
            $display("%0t: %s mismatch: expected mode %0d door %0b wrong %0d lockout %0b,",
                     $time, src, want.mode, want.door_open, want.wrong_count,
                     want.locked_out);
            $display("    actual mode %0d door %0b wrong %0d lockout %0b",
                     o_mode, o_door_open, o_wrong_count, o_locked_out);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pending ent;
        if (!i_rst_n) begin
            lk_mode = cll_pkg::MODE_NEW;
            lk_code = '0;
            lk_tries = '0;
            lk_timer = '0;
            reg_master = '0;
            reg_max_tries = cll_pkg::RST_MAX_ATTEMPTS;
            reg_open_ticks = cll_pkg::RST_OPEN_TICKS;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result beat with nothing expected:", $time);
                    $display("    mode %0d door %0b wrong %0d lockout %0b",
                             o_mode, o_door_open, o_wrong_count, o_locked_out);
                end else begin
                    ent = pending_results.pop_front();
                    compare_result(ent.pred, "predicted");
                    if (ent.typed) compare_result(ent.typed_val, "directed");
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cll_pkg::CFG_MASTER_CODE:  reg_master = i_cfg_data[7:0];
                    cll_pkg::CFG_MAX_ATTEMPTS: reg_max_tries = i_cfg_data[cll_pkg::CNT_W-1:0];
                    cll_pkg::CFG_OPEN_TICKS:   reg_open_ticks = i_cfg_data[cll_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                ent.pred = predict_lock(i_func, i_code);
                ent.typed = cur_typed;
                ent.typed_val = cur_res;
                pending_results.push_back(ent);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("code_lock_controller verification failed");
        $finish;
    end

    // Result side: a random hold-off per beat while idles are enabled, and one long hold to back up the input.
    initial begin : receiver
        int n;
        bit long_done;
        long_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!long_done && results_seen >= HOLD_AT) begin
                n = HOLD_CYCLES;
                long_done = 1'b1;
            end else begin
                n = idle_en ? $urandom_range(0, 4) : 0;
            end
            repeat (n) @(negedge i_clk) i_out_stall <= 1'b1;
            @(negedge i_clk) i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic send_beat(logic f, logic [7:0] c, bit typed, cll_pkg::t_result r);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func <= f;
        i_code <= c;
        cur_typed <= typed;
        cur_res <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [cll_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_beat(logic f, logic [7:0] c, bit typed, cll_pkg::t_result r);
        t_dir_row row;
        row = '{default: '0};
        row.func = f;
        row.code = c;
        row.typed = typed;
        row.res = r;
        dir_table.push_back(row);
    endtask

    task automatic add_cfg(logic [cll_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        t_dir_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        dir_table.push_back(row);
    endtask

    // Mostly codes that move the lock forward from its present mode, some noise.
    task automatic pick_beat(output logic f, output logic [7:0] c);
        int r;
        r = $urandom_range(0, 99);
        f = 1'b0;
        c = 8'($urandom_range(0, 255));
        case (lk_mode)
            cll_pkg::MODE_OPEN: begin
                if (r < 85) f = 1'b1;
            end
            cll_pkg::MODE_NEW: begin
                if (r < 8) f = 1'b1;
                else if (r < 16) c = cll_pkg::CHANGE_KEY;
                else if (r < 24) c = r[0] ? 8'hFF : 8'h00;
            end
            cll_pkg::MODE_ENTER: begin
                if (r < 8) f = 1'b1;
                else if (r < 16) c = cll_pkg::CHANGE_KEY;
                else if (r < 16 + hit_pct * 84 / 100) c = lk_code;
            end
            cll_pkg::MODE_MASTER: begin
                if (r < 8) f = 1'b1;
                else if (r < 8 + hit_pct * 92 / 100) c = reg_master;
            end
            default: begin
                if (r < 8) f = 1'b1;
                else if (r < 8 + hit_pct * 92 / 100) c = lk_code;
            end
        endcase
    endtask

    initial begin : stimulus
        logic        f;
        logic [7:0]  c;
        logic [15:0] ticks;
        logic [3:0]  tries;
        logic [7:0]  mcode;

        add_beat(1'b1, 8'h00, 1'b1, mk_res(cll_pkg::MODE_NEW, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'hFF, 1'b1, mk_res(cll_pkg::MODE_CONFIRM, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h00, 1'b1, mk_res(cll_pkg::MODE_NEW, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h00, 1'b1, mk_res(cll_pkg::MODE_CONFIRM, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h00, 1'b1, mk_res(cll_pkg::MODE_OPEN, 1'b1, 4'd0, 1'b0));
        add_beat(1'b0, 8'h12, 1'b1, mk_res(cll_pkg::MODE_OPEN, 1'b1, 4'd0, 1'b0));
        add_beat(1'b1, 8'h00, 1'b0, '0);
        add_beat(1'b1, 8'hFF, 1'b0, '0);
        add_beat(1'b1, 8'h00, 1'b1, mk_res(cll_pkg::MODE_ENTER, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'hFF, 1'b1, mk_res(cll_pkg::MODE_ENTER, 1'b0, 4'd1, 1'b0));
        add_beat(1'b0, 8'h00, 1'b1, mk_res(cll_pkg::MODE_OPEN, 1'b1, 4'd0, 1'b0));
        repeat (3) add_beat(1'b1, 8'h00, 1'b0, '0);
        add_beat(1'b0, cll_pkg::CHANGE_KEY, 1'b1, mk_res(cll_pkg::MODE_OLD, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h55, 1'b0, '0);
        add_beat(1'b0, 8'h66, 1'b0, '0);
        add_beat(1'b0, 8'h77, 1'b1, mk_res(cll_pkg::MODE_MASTER, 1'b0, 4'd0, 1'b1));
        add_beat(1'b1, 8'h00, 1'b1, mk_res(cll_pkg::MODE_MASTER, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h01, 1'b1, mk_res(cll_pkg::MODE_MASTER, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h00, 1'b1, mk_res(cll_pkg::MODE_NEW, 1'b0, 4'd0, 1'b0));
        // A stored code equal to the change key opens only through confirm.
        add_beat(1'b0, cll_pkg::CHANGE_KEY, 1'b0, '0);
        add_beat(1'b0, cll_pkg::CHANGE_KEY, 1'b1,
                 mk_res(cll_pkg::MODE_OPEN, 1'b1, 4'd0, 1'b0));
        add_cfg(cll_pkg::CFG_OPEN_TICKS, 16'h0000);
        add_cfg(cll_pkg::CFG_MAX_ATTEMPTS, 16'h0000);
        add_cfg(cll_pkg::CFG_MASTER_CODE, 16'h00FF);
        // The door was opened with three ticks loaded, so it runs those out first.
        repeat (2) add_beat(1'b1, 8'h00, 1'b0, '0);
        add_beat(1'b1, 8'h00, 1'b1, mk_res(cll_pkg::MODE_ENTER, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, cll_pkg::CHANGE_KEY, 1'b1, mk_res(cll_pkg::MODE_OLD, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h01, 1'b1, mk_res(cll_pkg::MODE_MASTER, 1'b0, 4'd0, 1'b1));
        add_beat(1'b0, 8'hFF, 1'b1, mk_res(cll_pkg::MODE_NEW, 1'b0, 4'd0, 1'b0));
        add_beat(1'b0, 8'h80, 1'b0, '0);
        // With a zero open time a single tick closes the door.
        add_beat(1'b0, 8'h80, 1'b1, mk_res(cll_pkg::MODE_OPEN, 1'b1, 4'd0, 1'b0));
        add_beat(1'b1, 8'h00, 1'b1, mk_res(cll_pkg::MODE_ENTER, 1'b0, 4'd0, 1'b0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg) begin
                quiesce();
                write_reg(dir_table[i].idx, dir_table[i].data);
            end else begin
                send_beat(dir_table[i].func, dir_table[i].code, dir_table[i].typed,
                          dir_table[i].res);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiesce();
            idle_en = (ph % 3) != 2;
            case (ph)
                0: begin mcode = 8'h00; tries = 4'd1;  ticks = 16'd1; end
                1: begin mcode = 8'hFF; tries = 4'd15; ticks = 16'd2; end
                2: begin mcode = 8'($urandom_range(0, 255)); tries = 4'd0; ticks = 16'd0; end
                3: begin mcode = 8'($urandom_range(0, 255)); tries = 4'($urandom_range(1, 15));
                         ticks = 16'd40; end
                NUM_PHASES - 1: begin mcode = 8'($urandom_range(0, 255));
                         tries = 4'($urandom_range(1, 15)); ticks = 16'hFFFF; end
                default: begin mcode = 8'($urandom_range(0, 255));
                         tries = 4'($urandom_range(1, 15));
                         ticks = 16'($urandom_range(1, 6)); end
            endcase
            // Few correct entries while fifteen misses are allowed, to run the count up.
            hit_pct = (ph == 1) ? 5 : $urandom_range(15, 90);
            write_reg(cll_pkg::CFG_MASTER_CODE, {8'h00, mcode});
            write_reg(cll_pkg::CFG_MAX_ATTEMPTS, {12'h000, tries});
            write_reg(cll_pkg::CFG_OPEN_TICKS, ticks);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick_beat(f, c);
                send_beat(f, c, 1'b0, '0);
            end
        end

        quiesce();
        if (err_count == 0) begin
            $display("code_lock_controller verification clean");
        end else begin
            $display("code_lock_controller verification failed");
        end
        $finish;
    end

endmodule
